// File: hw/rtl/rnew_pkg.sv
// ----------------------------------------------------------------------------
// rnew_pkg
// Shared constants and types for the neighbor edge weight unit.
// ----------------------------------------------------------------------------
package rnew_pkg;

    localparam int MaxWidth  = 2048;
    localparam int MaxHeight = 2048;
    localparam int FracBits  = 8;

    localparam int ColW  = $clog2(MaxWidth);
    localparam int RowW  = $clog2(MaxHeight);
    localparam int CfgW  = 12;
    localparam int SlotW = 24;
    localparam int NodeW = 22;
    localparam int WtW   = 17;
    localparam int PixW  = 24;
    // squared distance scaled by 2^(2*FracBits)
    localparam int SqW   = 18 + 2 * FracBits;
    localparam int AddrW = 3;

    localparam logic [AddrW-1:0] RegWidth  = 3'd0;
    localparam logic [AddrW-1:0] RegHeight = 3'd4;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel;

    typedef struct packed {
        logic [SlotW-1:0] edge_slot;
        logic [NodeW-1:0] node_from;
        logic [NodeW-1:0] node_to;
        logic [WtW-1:0]   weight;
        logic             last_of_run;
    } t_edge;

endpackage

// File: hw/rtl/rnew_if.sv
// ----------------------------------------------------------------------------
// rnew_pix_if / rnew_edge_if
// Valid/ready channels for pixels in and edges out.
// ----------------------------------------------------------------------------
interface rnew_pix_if;
    logic               valid;
    logic               ready;
    rnew_pkg::t_pixel   payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface rnew_edge_if;
    logic               valid;
    logic               ready;
    rnew_pkg::t_edge    payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: hw/rtl/rgb_neighbor_edge_weights_unit.sv
// ----------------------------------------------------------------------------
// rgb_neighbor_edge_weights_unit
// Streams raster pixels, emits 8-connected graph edges with color distance.
// ----------------------------------------------------------------------------
// The first edge of a pixel is registered after the read, prepare, serial square
// root and output states (StRead, StPrep, StSqrt, StOut). Each edge needs its own
// serial square root, and output stalls can hold a pixel in work;
// one pixel is in work at a time.
// The previous row lives in a 2048x24 single-port-read RAM with a registered read.
// Reset (synchronous, active low) clears position, neighbor pixels and the
// handshakes; the row RAM is not cleared and its read values are only used after being written.
module rgb_neighbor_edge_weights_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    rnew_pix_if.sink                  i_pix,
    rnew_edge_if.source               o_edge,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [rnew_pkg::AddrW-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    import rnew_pkg::*;

    localparam logic [2:0] StIdle = 3'd0;
    localparam logic [2:0] StRead = 3'd1;
    localparam logic [2:0] StPrep = 3'd2;
    localparam logic [2:0] StSqrt = 3'd3;
    localparam logic [2:0] StOut  = 3'd4;
    localparam int SqSteps = SqW / 2;

    // configuration registers
    logic [CfgW-1:0] r_width, r_height;
    logic            cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        case (paddr)
            RegWidth:  prdata = {20'd0, r_width};
            RegHeight: prdata = {20'd0, r_height};
            default:   prdata = 32'd0;
        endcase
    end

    // effective (clamped) frame size
    logic [CfgW-1:0] w_eff, h_eff;
    always_comb begin
        w_eff = r_width;
        if (r_width < CfgW'(2)) w_eff = CfgW'(2);
        else if (r_width > CfgW'(MaxWidth)) w_eff = CfgW'(MaxWidth);
        h_eff = r_height;
        if (r_height < CfgW'(2)) h_eff = CfgW'(2);
        else if (r_height > CfgW'(MaxHeight)) h_eff = CfgW'(MaxHeight);
    end

    // row memory
    logic [PixW-1:0] mem_row [MaxWidth];
    logic [PixW-1:0] r_up;
    logic            mem_we;
    logic [ColW-1:0] mem_addr;

    // control and datapath registers
    logic [2:0]       r_state;
    logic [CfgW-1:0]  r_col, r_row;
    logic [PixW-1:0]  r_left, r_uleft, r_cur;
    logic [1:0]       r_k;            // edge kind in work
    logic [SlotW-1:0] r_base, r_top;  // (row-1)*M*4 style bases
    logic [NodeW-1:0] r_rowbase;      // y*W
    logic [SqW-1:0]   r_v, r_res, r_bit;
    logic [4:0]       r_cnt;
    t_edge            r_out;
    logic             r_ovalid;
    logic             out_load;

    assign mem_addr = r_col[ColW-1:0];
    assign mem_we   = (r_state == StPrep);

    // pixel above is read once per pixel, before this pixel overwrites it
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_row[mem_addr] <= r_cur;
        end
        if (r_state == StRead) begin
            r_up <= mem_row[mem_addr];
        end
    end

    assign i_pix.ready = (r_state == StIdle) && !cfg_wr;
    assign out_load    = (r_state == StOut) && (!r_ovalid || o_edge.ready);

    // per-edge selection for kind k
    logic [CfgW-1:0]  m_val;
    logic             has_x, has_y, at_last_col;
    logic [PixW-1:0]  pa, pb;
    logic [1:0]       nk;
    logic             nk_ok;
    logic [SlotW-1:0] slot;
    logic [NodeW-1:0] nfrom, nto;
    logic [23:0]      sq_sum;
    logic [8:0]       dr, dg, db;
    logic [CfgW-1:0]  src_row, src_col;
    logic [1:0]       src_kind;

    assign m_val       = w_eff - CfgW'(1);
    assign has_x       = (r_col != '0);
    assign has_y       = (r_row != '0);
    assign at_last_col = (r_col == m_val);

    function automatic logic kind_ok(input logic [1:0] k, input logic hx, input logic hy);
        case (k)
            2'd0:    kind_ok = hx;
            2'd1:    kind_ok = hy;
            default: kind_ok = hx && hy;
        endcase
    endfunction

    always_comb begin
        nk = r_k + 2'd1;
        nk_ok = 1'b0;
        if (r_k != 2'd3) begin
            nk_ok = kind_ok(nk, has_x, has_y);
            if (!nk_ok && nk != 2'd3) begin
                nk = nk + 2'd1;
                nk_ok = kind_ok(nk, has_x, has_y);
                if (!nk_ok && nk != 2'd3) begin
                    nk = nk + 2'd1;
                    nk_ok = kind_ok(nk, has_x, has_y);
                end
            end
        end
        case (r_k)
            2'd0: begin pa = r_left;  pb = r_cur; end
            2'd1: begin pa = r_up;    pb = r_cur; end
            2'd2: begin pa = r_uleft; pb = r_cur; end
            default: begin pa = r_left; pb = r_up; end
        endcase
        dr = {1'b0, pa[23:16]} - {1'b0, pb[23:16]};
        dg = {1'b0, pa[15:8]}  - {1'b0, pb[15:8]};
        db = {1'b0, pa[7:0]}   - {1'b0, pb[7:0]};
        if (dr[8]) dr = -dr;
        if (dg[8]) dg = -dg;
        if (db[8]) db = -db;
        sq_sum = 24'(dr[7:0] * dr[7:0]) + 24'(dg[7:0] * dg[7:0])
               + 24'(db[7:0] * db[7:0]);
        // source pixel of the edge
        case (r_k)
            2'd0: begin src_row = r_row; src_col = r_col - CfgW'(1); end
            2'd1: begin src_row = r_row - CfgW'(1); src_col = r_col; end
            2'd2: begin src_row = r_row - CfgW'(1); src_col = r_col - CfgW'(1); end
            default: begin src_row = r_row; src_col = r_col - CfgW'(1); end
        endcase
        src_kind = r_k;
        nfrom = NodeW'(r_rowbase) + NodeW'(src_col)
              - ((src_row != r_row) ? NodeW'(w_eff) : NodeW'(0));
        case (r_k)
            2'd0:    nto = nfrom + NodeW'(1);
            2'd1:    nto = nfrom + NodeW'(w_eff);
            2'd2:    nto = nfrom + NodeW'(w_eff) + NodeW'(1);
            default: nto = nfrom - NodeW'(w_eff) + NodeW'(1);
        endcase
        // slot: r_top = 4*M*(H-2), r_base = 4*M*(row-1) for current row
        if (r_k == 2'd1 && at_last_col) begin
            slot = r_top + SlotW'(5) * SlotW'(m_val) + SlotW'(src_row);
        end else if (src_row == '0) begin
            slot = r_top + SlotW'(3) * SlotW'(src_col) + SlotW'(src_kind);
        end else if (src_row == h_eff - CfgW'(1)) begin
            slot = r_top + SlotW'(3) * SlotW'(m_val) + SlotW'(2) * SlotW'(src_col)
                 + ((src_kind == 2'd0) ? SlotW'(0) : SlotW'(1));
        end else begin
            slot = ((src_row == r_row) ? r_base : r_base - SlotW'(4) * SlotW'(m_val))
                 + SlotW'(4) * SlotW'(src_col) + SlotW'(src_kind);
        end
    end

    // serial square root step
    logic [SqW-1:0] rb;
    assign rb = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= CfgW'(640);
            r_height <= CfgW'(480);
            r_state  <= StIdle;
            r_col    <= '0;
            r_row    <= '0;
            r_left   <= '0;
            r_uleft  <= '0;
            r_ovalid <= 1'b0;
            r_rowbase <= '0;
            r_base   <= '0;
            r_k      <= '0;
        end else begin
            // output register: load a new edge or clear once taken
            if (out_load) r_ovalid <= 1'b1;
            else if (o_edge.ready) r_ovalid <= 1'b0;
            if (cfg_wr) begin
                if (paddr == RegWidth) r_width <= pwdata[CfgW-1:0];
                if (paddr == RegHeight) r_height <= pwdata[CfgW-1:0];
                if (paddr == RegWidth || paddr == RegHeight) begin
                    r_col <= '0; r_row <= '0; r_left <= '0; r_uleft <= '0;
                    r_rowbase <= '0; r_base <= '0;
                end
            end
            r_top <= SlotW'(4) * SlotW'(m_val) * SlotW'(h_eff - CfgW'(2));
            case (r_state)
                StIdle: begin
                    if (i_pix.valid && i_pix.ready) begin
                        r_cur <= i_pix.payload;
                        if (r_col >= w_eff || r_row >= h_eff) begin
                            r_col <= '0; r_row <= '0; r_rowbase <= '0; r_base <= '0;
                        end
                        r_state <= StRead;
                    end
                end
                StRead: begin
                    r_k <= (!has_x && has_y) ? 2'd1 : 2'd0;
                    r_state <= StPrep;
                end
                StPrep: begin
                    // r_up valid; memory written this cycle
                    if (!has_x && !has_y) begin
                        r_left <= r_cur;
                        r_uleft <= r_up;
                        r_col <= r_col + CfgW'(1);
                        r_state <= StIdle;
                    end else begin
                        r_v   <= SqW'(sq_sum) << (2 * FracBits);
                        r_res <= '0;
                        r_bit <= SqW'(1) << (SqW - 2);
                        r_cnt <= '0;
                        r_state <= StSqrt;
                    end
                end
                StSqrt: begin
                    if (r_v >= rb) begin
                        r_v   <= r_v - rb;
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'(SqSteps - 1)) r_state <= StOut;
                end
                StOut: begin
                    if (out_load) begin
                        r_out.edge_slot   <= slot;
                        r_out.node_from   <= nfrom;
                        r_out.node_to     <= nto;
                        r_out.weight      <= r_res[WtW-1:0];
                        r_out.last_of_run <= !nk_ok;
                        if (nk_ok) begin
                            r_k <= nk;
                            r_state <= StPrep;
                        end else begin
                            r_state <= StIdle;
                            if (at_last_col) begin
                                r_col <= '0;
                                r_left <= '0;
                                r_uleft <= '0;
                                if (r_row == h_eff - CfgW'(1)) begin
                                    r_row <= '0; r_rowbase <= '0; r_base <= '0;
                                end else begin
                                    r_row <= r_row + CfgW'(1);
                                    r_rowbase <= r_rowbase + NodeW'(w_eff);
                                    if (has_y) r_base <= r_base + SlotW'(4) * SlotW'(m_val);
                                end
                            end else begin
                                r_col <= r_col + CfgW'(1);
                                r_left <= r_cur;
                                r_uleft <= r_up;
                            end
                        end
                    end
                end
                default: r_state <= StIdle;
            endcase
        end
    end

    assign o_edge.valid   = r_ovalid;
    assign o_edge.payload = r_out;

    // a new pixel is only taken when idle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pix.valid && i_pix.ready) |-> r_state == StIdle)
        else $error("pixel accepted while busy");
    // a stalled edge keeps its payload
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_edge.valid && !o_edge.ready) |=> $stable(o_edge.payload))
        else $error("edge payload changed under stall");
    // the root iteration ends in the output state
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == StSqrt && r_cnt == 5'(SqSteps - 1)) |=> r_state == StOut)
        else $error("square root step count broken");
endmodule

// File: verif/rnew_edge_checker.sv
// ----------------------------------------------------------------------------
// rnew_edge_checker
// Watches the pixel and edge channels and the register port, predicts the
// graph edges each accepted pixel causes and compares them in order.
// ----------------------------------------------------------------------------
module rnew_edge_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_pix_valid,
    input  logic                         i_pix_ready,
    input  rnew_pkg::t_pixel             i_pix_data,
    input  logic                         i_edge_valid,
    input  logic                         i_edge_ready,
    input  rnew_pkg::t_edge              i_edge_data,
    input  logic                         i_psel,
    input  logic                         i_penable,
    input  logic                         i_pwrite,
    input  logic                         i_pready,
    input  logic [rnew_pkg::AddrW-1:0]   i_paddr,
    input  logic [31:0]                  i_pwdata,
    output int                           o_fail_count,
    output int                           o_pending,
    output int                           o_edge_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import rnew_pkg::*;

    // predictor state
    logic [CfgW-1:0] cfg_width;
    logic [CfgW-1:0] cfg_height;
    logic [PixW-1:0] row_store [MaxWidth];
    logic [PixW-1:0] left_px;
    logic [PixW-1:0] upleft_px;
    int unsigned     col;
    int unsigned     row;
    t_edge           edge_queue [$];

    // exact floor(sqrt(sum of squared channel differences) * 2^FracBits)
    function automatic logic [WtW-1:0] color_distance(logic [PixW-1:0] a,
                                                      logic [PixW-1:0] b);
        longint unsigned s;
        longint unsigned r;
        longint unsigned bitv;
        int d;
        s = 0;
        for (int c = 0; c < 3; c++) begin
            d = int'(a[c*8 +: 8]) - int'(b[c*8 +: 8]);
            s += longint'(d * d);
        end
        s = s << (2 * FracBits);
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > s) bitv >>= 2;
        while (bitv != 0) begin
            if (s >= r + bitv) begin
                s -= r + bitv;
                r = (r >> 1) + bitv;
            end else begin
                r >>= 1;
            end
            bitv >>= 2;
        end
        return r[WtW-1:0];
    endfunction

    function automatic longint unsigned edge_slot_of(longint unsigned y, longint unsigned x,
                                                     int kind, longint unsigned w,
                                                     longint unsigned h);
        longint unsigned m;
        longint unsigned base;
        m = w - 1;
        base = 4 * m * (h - 2);
        if (y == 0) return base + 3 * x + kind;
        if (y == h - 1) return base + 3 * m + 2 * x + (kind == 0 ? 0 : 1);
        return ((y - 1) * m + x) * 4 + kind;
    endfunction

    function automatic void push_edge(longint unsigned slot, longint unsigned from,
                                      longint unsigned to, logic [WtW-1:0] wt);
        t_edge e;
        e.edge_slot   = slot[SlotW-1:0];
        e.node_from   = from[NodeW-1:0];
        e.node_to     = to[NodeW-1:0];
        e.weight      = wt;
        e.last_of_run = 1'b0;
        edge_queue.push_back(e);
    endfunction

    function automatic void predict_pixel(logic [PixW-1:0] cur);
        longint unsigned w, h, x, y, p, s;
        logic [PixW-1:0] up;
        int n;
        w = (cfg_width < 2) ? 2 : (cfg_width > MaxWidth ? MaxWidth : cfg_width);
        h = (cfg_height < 2) ? 2 : (cfg_height > MaxHeight ? MaxHeight : cfg_height);
        x = col;
        y = row;
        if (x >= w || y >= h) begin
            x = 0;
            y = 0;
        end
        up = row_store[x];
        n = 0;
        if (x >= 1) begin
            p = y * w + x - 1;
            push_edge(edge_slot_of(y, x - 1, 0, w, h), p, p + 1, color_distance(left_px, cur));
            n++;
        end
        if (y >= 1) begin
            p = (y - 1) * w + x;
            s = (x == w - 1) ? 4 * (w - 1) * (h - 2) + 5 * (w - 1) + (y - 1)
                             : edge_slot_of(y - 1, x, 1, w, h);
            push_edge(s, p, p + w, color_distance(up, cur));
            n++;
        end
        if (y >= 1 && x >= 1) begin
            p = (y - 1) * w + x - 1;
            push_edge(edge_slot_of(y - 1, x - 1, 2, w, h), p, p + w + 1,
                      color_distance(upleft_px, cur));
            p = y * w + x - 1;
            push_edge(edge_slot_of(y, x - 1, 3, w, h), p, p - w + 1,
                      color_distance(left_px, up));
            n += 2;
        end
        if (n > 0) edge_queue[$].last_of_run = 1'b1;
        upleft_px = up;
        row_store[x] = cur;
        left_px = cur;
        x++;
        if (x >= w) begin
            x = 0;
            y++;
            if (y >= h) y = 0;
            left_px = '0;
            upleft_px = '0;
        end
        col = x;
        row = y;
    endfunction

    // sample all handshakes at the clock edge
    always @(posedge i_clk) begin
        t_edge exp_e;
        if (!i_rst_n) begin
            cfg_width    = 12'd640;
            cfg_height   = 12'd480;
            col          = 0;
            row          = 0;
            left_px      = '0;
            upleft_px    = '0;
            o_fail_count <= 0;
            o_edge_count <= 0;
            edge_queue.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr == RegWidth) cfg_width = i_pwdata[CfgW-1:0];
                else if (i_paddr == RegHeight) cfg_height = i_pwdata[CfgW-1:0];
                if (i_paddr == RegWidth || i_paddr == RegHeight) begin
                    col = 0;
                    row = 0;
                    left_px = '0;
                    upleft_px = '0;
                end
            end
            if (i_edge_valid && i_edge_ready) begin
                o_edge_count <= o_edge_count + 1;
                if (edge_queue.size() == 0) begin
                    $error("edge transaction with nothing expected: %p", i_edge_data);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_e = edge_queue.pop_front();
                    if (exp_e != i_edge_data) o_fail_count <= o_fail_count + 1;
                    if (exp_e.edge_slot != i_edge_data.edge_slot)
                        $error("edge_slot: expected %0d, got %0d",
                               exp_e.edge_slot, i_edge_data.edge_slot);
                    if (exp_e.node_from != i_edge_data.node_from)
                        $error("node_from: expected %0d, got %0d",
                               exp_e.node_from, i_edge_data.node_from);
                    if (exp_e.node_to != i_edge_data.node_to)
                        $error("node_to: expected %0d, got %0d",
                               exp_e.node_to, i_edge_data.node_to);
                    if (exp_e.weight != i_edge_data.weight)
                        $error("weight: expected %0d, got %0d",
                               exp_e.weight, i_edge_data.weight);
                    if (exp_e.last_of_run != i_edge_data.last_of_run)
                        $error("last_of_run: expected %0d, got %0d",
                               exp_e.last_of_run, i_edge_data.last_of_run);
                end
            end
            // predict after the pop so a same-cycle result never matches itself
            if (i_pix_valid && i_pix_ready) predict_pixel(i_pix_data);
        end
    end

    assign o_pending = edge_queue.size();

endmodule

// File: verif/rgb_neighbor_edge_weights_unit_tb.sv
// ----------------------------------------------------------------------------
// rgb_neighbor_edge_weights_unit_tb
// Streams frames of several sizes through the edge unit with random gaps
// and back-pressure; a checker beside it predicts and compares every edge.
// ----------------------------------------------------------------------------
module rgb_neighbor_edge_weights_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rnew_pkg::*;

    localparam int IdleLimit   = 20000;
    localparam int DrainCycles = 200;

    logic i_clk;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [AddrW-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    int fail_count;
    int pending;
    int edge_count;
    int pixels_sent;
    int idle_cycles;
    bit long_hold;

    rnew_pix_if  pix_ch ();
    rnew_edge_if edge_ch ();

    rgb_neighbor_edge_weights_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_ch.sink),
        .o_edge  (edge_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    rnew_edge_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pix_valid  (pix_ch.valid),
        .i_pix_ready  (pix_ch.ready),
        .i_pix_data   (pix_ch.payload),
        .i_edge_valid (edge_ch.valid),
        .i_edge_ready (edge_ch.ready),
        .i_edge_data  (edge_ch.payload),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_edge_count (edge_count)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // mostly short gaps, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic reg_write(logic [AddrW-1:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // one pixel transaction; valid stays high across back-to-back items
    task automatic send_pixel(t_pixel px, bit with_gap);
        int g;
        g = with_gap ? gap_len() : 0;
        if (g > 0) begin
            pix_ch.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        pix_ch.valid   <= 1'b1;
        pix_ch.payload <= px;
        @(posedge i_clk);
        while (!pix_ch.ready) @(posedge i_clk);
        pixels_sent++;
    endtask

    task automatic idle_pix();
        pix_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // let the block finish all edges before touching the registers
    task automatic wait_drained();
        idle_pix();
        while (pending != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic set_size(int w, int h);
        wait_drained();
        reg_write(RegWidth, 32'(w));
        reg_write(RegHeight, 32'(h));
    endtask

    function automatic t_pixel rand_pixel();
        t_pixel p;
        int k;
        k = $urandom_range(0, 9);
        p = t_pixel'(24'($urandom()));
        if (k == 0) p = '0;
        else if (k == 1) p = '1;
        else if (k == 2) p = {8'(($urandom_range(0, 1)) * 255), 8'(($urandom_range(0, 1)) * 255),
                              8'(($urandom_range(0, 1)) * 255)};
        return p;
    endfunction

    task automatic send_frame(int n);
        for (int i = 0; i < n; i++) send_pixel(rand_pixel(), 1'b1);
    endtask

    // edge receiver: random stalls plus one long hold-off
    initial begin
        int g;
        bit held;
        held = 1'b0;
        edge_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (long_hold && !held) begin
                edge_ch.ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                held = 1'b1;
            end
            g = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
            if (g > 0) begin
                edge_ch.ready <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
            edge_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (pix_ch.valid && pix_ch.ready) || (edge_ch.valid && edge_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IdleLimit) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        int w;
        int h;
        i_rst_n        <= 1'b0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        pix_ch.valid   <= 1'b0;
        pix_ch.payload <= '0;
        pixels_sent    = 0;
        long_hold      = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: 2x2 frame with extreme colors, then 3x3 with max differences
        set_size(2, 2);
        send_pixel(24'h000000, 1'b0);
        send_pixel(24'hFFFFFF, 1'b0);
        send_pixel(24'hFF0000, 1'b0);
        send_pixel(24'h00FFFF, 1'b0);
        send_pixel(24'h123456, 1'b0);    // wraps back to the frame origin
        set_size(3, 3);
        for (int i = 0; i < 9; i++)
            send_pixel((i % 2) ? 24'hFFFFFF : 24'h000000, 1'b0);
        // out-of-range sizes clamp; restart mid frame
        set_size(0, 1);
        send_pixel(24'hAA55AA, 1'b0);
        send_pixel(24'h55AA55, 1'b0);
        set_size(4095, 3);
        for (int i = 0; i < 5; i++) send_pixel(rand_pixel(), 1'b0);

        // long hold-off while pixels keep coming
        set_size(4, 4);
        long_hold = 1'b1;
        send_frame(16);

        // random frames, mostly small
        while (pixels_sent < 240) begin
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(2, 6);
            h = $urandom_range(2, 5);
            set_size(w, h);
            send_frame(w * h + (($urandom_range(0, 3) == 0) ? $urandom_range(1, w) : 0));
        end
        // largest width: a short partial first row
        set_size(2048, 2048);
        send_frame(20);
        set_size(2048, 2);
        send_frame(8);

        wait_drained();
        $display("Covered %0d pixels and %0d edges over frame sizes 2x2 to 2048 wide,",
                 pixels_sent, edge_count);
        $display("with clamped sizes, mid-frame restarts and receiver back-pressure.");
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: rgb_neighbor_edge_weights_unit.f
hw/rtl/rnew_pkg.sv
hw/rtl/rnew_if.sv
hw/rtl/rgb_neighbor_edge_weights_unit.sv
verif/rnew_edge_checker.sv
verif/rgb_neighbor_edge_weights_unit_tb.sv
